// ----- hdl/bounded_ordered_list_assert.svh -----
// Assertion macros for the ordered list block.
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

// Checked on every rising edge outside reset.
`define BOL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BOL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/bol_pkg.sv -----
`default_nettype none

package bol_pkg;

   // list storage
   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // field widths
   localparam int OPCODE_W    = 2;
   localparam int POS_W       = 7;
   localparam int HANDLE_W    = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;
   localparam int CAP_W       = 7;

   // width used to compare positions against the count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // stream widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_GET    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/bol_ram.sv -----
`default_nettype none

module bol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bounded_ordered_list.sv -----
// channel   dir  handshake                 payload
// req_      in   req_tvalid / req_tready   opcode, position, at_end, handle_in
// rsp_      out  rsp_tvalid / rsp_tready   status, handle_out, count_out, empty_res
// csr_      in   csr_wr_en                 capacity
//
// One beat at a time. A get reads the entry at p; an insert at p < n walks
// down from the top entry shifting each one up a slot, then writes the new
// handle; an insert at the end only writes it; a remove walks up from p,
// shifting each later entry down a slot. The shift walks the entry RAM one
// address per cycle (one read port, one write port); errors skip the RAM.
// Reset is synchronous, clears count and the control path; the entry RAM is
// not cleared, only entries below count are ever read.
// A result held on rsp_ does not block accepting the next beat; that beat's
// result waits in the final state until the output register frees up.
`default_nettype none

module bounded_ordered_list (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [6:0] position, [38:7] handle_in, [39] zero
   input  wire logic [bol_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode, [2] at_end
   input  wire logic [bol_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [31:0] handle_out, [38:32] count_out, [39] empty_res
   output logic      [bol_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic      [bol_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  wire logic                           csr_wr_en,
   // capacity
   input  wire logic [bol_pkg::CAP_W-1:0]      csr_wr_data
);

   import bol_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,   // stream reads through the RAM
      S_DRAIN,  // last read data lands
      S_PUT,    // insert writes the new handle
      S_DONE    // load output register
   } state_type;

   state_type state_ff, state_in;

   logic [OPCODE_W-1:0]    op_ff, op_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   logic [ADDR_W-1:0]      last_ff, last_in;
   logic [ADDR_W-1:0]      cur_ff, cur_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]      rd_addr_ff, rd_addr_in;
   logic [HANDLE_W-1:0]    handle_ff, handle_in;
   logic [HANDLE_W-1:0]    hout_ff, hout_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]  rsp_user_ff, rsp_user_in;

   // RAM ports
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [HANDLE_W-1:0] ram_wdata;
   logic                ram_re;
   logic [HANDLE_W-1:0] ram_rdata;

   // request fields
   logic [OPCODE_W-1:0] req_opcode;
   logic                req_at_end;
   logic [POS_W-1:0]    req_position;
   logic [HANDLE_W-1:0] req_handle;

   // position checks
   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] ins_pos;
   logic [CMP_W-1:0] acc_pos;
   logic             acc_ok;
   logic             full;
   logic [CNT_W-1:0] cnt_m1;

   assign req_opcode   = req_tuser[OPCODE_W-1:0];
   assign req_at_end   = req_tuser[OPCODE_W];
   assign req_position = req_tdata[POS_W-1:0];
   assign req_handle   = req_tdata[POS_W +: HANDLE_W];

   assign cnt_x   = CMP_W'(count_ff);
   assign cnt_m1  = count_ff - CNT_W'(1);
   assign ins_pos = req_at_end ? cnt_x : CMP_W'(req_position);
   assign acc_pos = req_at_end ? CMP_W'(cnt_m1) : CMP_W'(req_position);
   // at_end on an empty list is out of range
   assign acc_ok  = req_at_end ? (count_ff != '0) : (CMP_W'(req_position) < cnt_x);
   // capacity is limited to the RAM depth
   assign full    = (count_ff >= CNT_W'(MAX_ENTRIES)) || (cnt_x >= CMP_W'(cap_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   bol_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (cur_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;
      cur_in      = cur_ff;
      rd_vld_in   = 1'b0;
      rd_addr_in  = rd_addr_ff;
      handle_in   = handle_ff;
      hout_in     = hout_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      ram_we      = 1'b0;
      ram_waddr   = rd_addr_ff;
      ram_wdata   = ram_rdata;
      ram_re      = 1'b0;

      // read data from the previous cycle: shift it one slot or capture it
      if (rd_vld_ff) begin
         case (op_ff)
            OP_INSERT: begin
               ram_we    = 1'b1;
               ram_waddr = rd_addr_ff + ADDR_W'(1);
            end
            OP_REMOVE: begin
               if (rd_addr_ff == pos_ff) begin
                  hout_in = ram_rdata;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = rd_addr_ff - ADDR_W'(1);
               end
            end
            default: begin
               hout_in = ram_rdata;
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_opcode;
               handle_in = req_handle;
               hout_in   = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_opcode) inside
                  OP_INSERT: begin
                     if (req_handle == '0) begin
                        status_in = ST_NULL;
                     end else if (ins_pos > cnt_x) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in  = ins_pos[ADDR_W-1:0];
                        last_in = ins_pos[ADDR_W-1:0];
                        if (ins_pos == cnt_x) begin
                           state_in = S_PUT;
                        end else begin
                           // walk down from the top entry
                           cur_in   = cnt_m1[ADDR_W-1:0];
                           state_in = S_SCAN;
                        end
                     end
                  end
                  OP_GET, OP_REMOVE: begin
                     if (!acc_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        pos_in   = acc_pos[ADDR_W-1:0];
                        cur_in   = acc_pos[ADDR_W-1:0];
                        last_in  = (req_opcode == OP_REMOVE) ? cnt_m1[ADDR_W-1:0]
                                                             : acc_pos[ADDR_W-1:0];
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            ram_re     = 1'b1;
            rd_vld_in  = 1'b1;
            rd_addr_in = cur_ff;
            if (cur_ff == last_ff) begin
               state_in = S_DRAIN;
            end else if (op_ff == OP_INSERT) begin
               cur_in = cur_ff - ADDR_W'(1);
            end else begin
               cur_in = cur_ff + ADDR_W'(1);
            end
         end
         S_DRAIN: begin
            if (op_ff == OP_INSERT) begin
               state_in = S_PUT;
            end else begin
               if (op_ff == OP_REMOVE) begin
                  count_in = cnt_m1;
               end
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = handle_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {(count_ff == '0), COUNT_OUT_W'(count_ff), hout_ff};
               rsp_user_in = status_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_vld_ff  <= 1'b0;
         count_ff   <= '0;
         cap_ff     <= CAP_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         count_ff   <= count_in;
         cap_ff     <= cap_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      cur_ff      <= cur_in;
      rd_addr_ff  <= rd_addr_in;
      handle_ff   <= handle_in;
      hout_ff     <= hout_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

// ----- hdl/bol_checker.sv -----
`default_nettype none

`include "bounded_ordered_list_assert.svh"

module bol_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [bol_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic [bol_pkg::REQ_USER_W-1:0] req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bol_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [bol_pkg::RSP_USER_W-1:0] rsp_tuser,
   input wire logic                           csr_wr_en,
   input wire logic [bol_pkg::CAP_W-1:0]      csr_wr_data
);

   import bol_pkg::*;

   logic                req_take;
   logic                rsp_err;
   logic                rsp_stall;
   logic [HANDLE_W-1:0] rsp_handle;

   assign req_take   = req_tvalid && req_tready;
   assign rsp_err    = rsp_tvalid && (rsp_tuser != ST_OK);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_handle = rsp_tdata[HANDLE_W-1:0];

   // no result comes out of reset
   `BOL_ASSERT_ALWAYS(a_rst_quiet, reset |=> !rsp_tvalid, "result valid after reset")

   // one beat at a time: no back-to-back accept
   `BOL_ASSERT(a_one_beat, req_take |=> !req_tready, "second beat taken early")

   // errors never return a handle
   `BOL_ASSERT(a_err_handle, rsp_err |-> (rsp_handle == '0), "handle on error")

   // stalled result holds
   `BOL_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (.*);

`default_nettype wire

// ----- tb/bounded_ordered_list_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the bounded ordered list.
// Flow: a sequencer fills a queue of list operations, a clocked driver feeds
// them onto req_, a predictor runs each accepted beat against a local copy
// of the list, and a clocked monitor on rsp_ compares every result beat with
// the oldest prediction.
module bounded_ordered_list_tb;
   import bol_pkg::*;

   // opcode value the block has no operation for
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_STALL  = 300;  // receiver hold-off while the sender keeps pushing
   localparam int NUM_PHASES  = 8;
   localparam int PRESSURE_PH = 5;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      logic                at_end;
      logic [HANDLE_W-1:0] handle;
   } list_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [HANDLE_W-1:0]    handle;
      logic [COUNT_OUT_W-1:0] count;
      logic                   empty;
   } list_rsp_type;

   // DUT ports; every input known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [CAP_W-1:0]      csr_wr_data = '0;

   // operations waiting for the driver, results waiting for the monitor
   list_req_type ops_to_send [$];
   list_rsp_type rsp_due [$];

   // predictor's copy of the list
   logic [HANDLE_W-1:0] shadow_store [MAX_ENTRIES];
   int                  shadow_count = 0;
   int                  shadow_cap = int'(CAP_RESET);

   // stimulus shaping
   int send_idle_pct = 16;
   int rcv_idle_pct  = 54;
   int gen_count     = 0;   // fill level the queued ops will leave behind
   bit gen_filling   = 1'b1;
   int stalls_asked  = 0;

   // bookkeeping
   int cycle_count  = 0;
   int error_count  = 0;
   int ops_accepted = 0;
   int rsp_checked  = 0;
   int cap_writes   = 0;
   int peak_fill    = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   int phase_cap [NUM_PHASES] = '{127, 64, 1, -1, 0, 64, 2, 64};  // -1: pick at random
   int phase_len [NUM_PHASES] = '{300, 350, 150, 250, 150, 350, 150, 300};

   bounded_ordered_list uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      end
   endfunction

   // Applies one operation to the local list and returns the result beat.
   // Insert errors are ranked: null handle, then bad position, then full.
   function automatic list_rsp_type apply_list_op(input list_req_type r);
      list_rsp_type res;
      int           p;
      int           k;
      int           eff_cap;
      bit           in_range;
      res = '0;
      res.status = ST_OK;
      p = int'(r.pos);
      eff_cap = (shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : shadow_cap;
      if (r.op == OP_INSERT) begin
         if (r.at_end) p = shadow_count;
         if (r.handle == '0) begin
            res.status = ST_NULL;
         end else if (p > shadow_count) begin
            res.status = ST_RANGE;
         end else if (shadow_count >= eff_cap) begin
            res.status = ST_FULL;
         end else begin
            for (k = shadow_count; k > p; k--) shadow_store[k] = shadow_store[k-1];
            shadow_store[p] = r.handle;
            shadow_count++;
         end
      end else if (r.op == OP_GET || r.op == OP_REMOVE) begin
         // at_end on an empty list has no last entry to point at
         in_range = 1'b1;
         if (r.at_end) begin
            if (shadow_count == 0) in_range = 1'b0;
            else p = shadow_count - 1;
         end
         if (!in_range || p >= shadow_count) begin
            res.status = ST_RANGE;
         end else begin
            res.handle = shadow_store[p];
            if (r.op == OP_REMOVE) begin
               shadow_count--;
               for (k = p; k < shadow_count; k++) shadow_store[k] = shadow_store[k+1];
            end
         end
      end else begin
         res.status = ST_RANGE;
      end
      res.count = shadow_count[COUNT_OUT_W-1:0];
      res.empty = (shadow_count == 0);
      if (shadow_count > peak_fill) peak_fill = shadow_count;
      return res;
   endfunction

   function automatic void queue_op(input logic [OPCODE_W-1:0] op, input int pos,
                                    input bit at_end, input logic [HANDLE_W-1:0] handle);
      list_req_type r;
      r.op = op;
      r.pos = POS_W'(pos);
      r.at_end = at_end;
      r.handle = handle;
      ops_to_send.push_back(r);
   endfunction

   // Mostly well-formed ops aimed at the current fill level, swinging the
   // list between empty and full; the rest are broken or junk ops that
   // cannot change the fill level.
   function automatic list_req_type make_random_op();
      list_req_type r;
      int           eff_cap;
      int           pick;
      eff_cap = (shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : shadow_cap;
      r.at_end = 1'b0;
      r.pos = '0;
      r.handle = $urandom();
      if (r.handle == '0) r.handle = 32'd1;
      if (gen_count >= eff_cap) gen_filling = 1'b0;
      else if (gen_count == 0) gen_filling = 1'b1;
      else if ($urandom_range(99) < 2) gen_filling = !gen_filling;
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(4))
            0: begin
               r.op = OP_GET;
               r.pos = POS_W'($urandom());
               r.at_end = 1'($urandom());
               r.handle = $urandom();
            end
            1: begin
               r.op = OP_UNUSED;
               r.pos = POS_W'($urandom());
               r.at_end = 1'($urandom());
               r.handle = $urandom();
            end
            2: begin
               r.op = OP_INSERT;
               r.pos = POS_W'($urandom());
               r.at_end = 1'($urandom());
               r.handle = '0;
            end
            3: begin
               r.op = OP_INSERT;
               r.pos = POS_W'($urandom_range(127, gen_count + 1));
            end
            default: begin
               r.op = OP_REMOVE;
               r.pos = POS_W'($urandom_range(127, gen_count));
            end
         endcase
      end else begin
         pick = $urandom_range(99);
         if (pick < (gen_filling ? 60 : 25)) r.op = OP_INSERT;
         else if (pick < (gen_filling ? 75 : 40)) r.op = OP_GET;
         else r.op = OP_REMOVE;
         r.at_end = ($urandom_range(3) == 0);
         if (r.at_end) r.pos = POS_W'($urandom());  // ignored when at_end is set
         else if (r.op == OP_INSERT) r.pos = POS_W'($urandom_range(gen_count, 0));
         else if (gen_count > 0) r.pos = POS_W'($urandom_range(gen_count - 1, 0));
         if (r.op == OP_INSERT && gen_count < eff_cap) gen_count++;
         else if (r.op == OP_REMOVE && gen_count > 0) gen_count--;
      end
      return r;
   endfunction

   // Driver: one beat on req_ at a time, random gaps between beats.
   // The prediction is made at the edge where the beat is taken.
   always @(posedge clock) begin : req_driver
      list_req_type nxt;
      list_req_type on_bus;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_due.push_back(apply_list_op(on_bus));
            ops_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = ops_to_send.pop_front();
               on_bus = nxt;
               req_tdata <= {1'b0, nxt.handle, nxt.pos};
               req_tuser <= {nxt.at_end, nxt.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each rsp_ beat and drives rsp_tready, including the
   // long hold-off the sequencer asks for.
   always @(posedge clock) begin : rsp_monitor
      list_rsp_type got;
      list_rsp_type want;
      int           stall_left;
      int           stalls_served;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         stalls_served = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser[STATUS_W-1:0];
            got.handle = rsp_tdata[31:0];
            got.count = rsp_tdata[38:32];
            got.empty = rsp_tdata[39];
            if (rsp_due.size() == 0) begin
               flag_error($sformatf("result with nothing pending: status %0d handle %h",
                                    got.status, got.handle));
            end else begin
               want = rsp_due.pop_front();
               status_seen[want.status]++;
               if (got.status !== want.status || got.handle !== want.handle ||
                   got.count !== want.count || got.empty !== want.empty) begin
                  flag_error($sformatf({"result %0d: expected status %0d handle %h ",
                                        "count %0d empty %0d, got status %0d handle %h ",
                                        "count %0d empty %0d"},
                                       rsp_checked, want.status, want.handle, want.count,
                                       want.empty, got.status, got.handle, got.count,
                                       got.empty));
               end
               rsp_checked++;
            end
         end
         if (stalls_served != stalls_asked) begin
            stall_left = LONG_STALL;
            stalls_served++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Sender pause: nothing queued, nothing on the bus, no result outstanding.
   task automatic wait_for_drain(input int settle);
      do @(negedge clock);
      while (ops_to_send.size() != 0 || req_tvalid || rsp_due.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // only called while the block is idle
   task automatic write_capacity(input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CAP_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_cap = value;
      cap_writes++;
   endtask

   initial begin : sequencer
      int ph;
      int i;
      int cap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list errors, insert error ranking, front/middle/back
      // inserts, reads, removes and the unused opcode (capacity at reset)
      queue_op(OP_GET, 0, 1'b0, 32'h1234_5678);
      queue_op(OP_REMOVE, 0, 1'b1, 32'h0);      // at_end on empty
      queue_op(OP_GET, 0, 1'b1, 32'h0);
      queue_op(OP_INSERT, 0, 1'b0, 32'h0);      // null handle
      queue_op(OP_INSERT, 127, 1'b0, 32'h0);    // null wins over bad position
      queue_op(OP_INSERT, 1, 1'b0, 32'hDEAD_BEEF);
      queue_op(OP_INSERT, 0, 1'b0, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 127, 1'b1, 32'h0000_0001);
      queue_op(OP_INSERT, 1, 1'b0, 32'h8000_0000);
      queue_op(OP_INSERT, 0, 1'b0, 32'h5A5A_5A5A);
      queue_op(OP_GET, 0, 1'b0, 32'h0);
      queue_op(OP_GET, 127, 1'b1, 32'h0);
      queue_op(OP_GET, 4, 1'b0, 32'h0);         // position == count
      queue_op(OP_GET, 127, 1'b0, 32'hFFFF_FFFF);
      queue_op(OP_UNUSED, 0, 1'b0, 32'hA5A5_A5A5);
      queue_op(OP_REMOVE, 1, 1'b0, 32'h0);
      queue_op(OP_REMOVE, 0, 1'b1, 32'h0);
      queue_op(OP_REMOVE, 5, 1'b0, 32'h0);
      wait_for_drain(8);

      // capacity reached: full, but null and bad position still rank first
      write_capacity(2);
      queue_op(OP_INSERT, 0, 1'b0, 32'h0BAD_F00D);
      queue_op(OP_INSERT, 0, 1'b0, 32'h0);
      queue_op(OP_INSERT, 3, 1'b0, 32'h0BAD_F00D);
      wait_for_drain(8);

      // capacity below count keeps the entries, only blocks inserts
      write_capacity(1);
      queue_op(OP_GET, 1, 1'b0, 32'h0);
      queue_op(OP_INSERT, 0, 1'b1, 32'h7777_7777);
      wait_for_drain(8);

      // zero capacity: every valid insert is full
      write_capacity(0);
      queue_op(OP_REMOVE, 0, 1'b0, 32'h0);
      queue_op(OP_INSERT, 0, 1'b0, 32'h1111_1111);
      wait_for_drain(8);

      // random phases, one capacity each; idle mix changes every few phases
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 54;
            rcv_idle_pct = 16;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         cap = phase_cap[ph];
         if (cap < 0) cap = $urandom_range(63, 3);
         write_capacity(cap);
         @(negedge clock);
         gen_count = shadow_count;
         gen_filling = 1'b1;
         // receiver goes quiet while the whole phase is queued behind it
         if (ph == PRESSURE_PH) stalls_asked++;
         for (i = 0; i < phase_len[ph]; i++) ops_to_send.push_back(make_random_op());
         wait_for_drain(8);
      end

      wait_for_drain(MAX_ENTRIES + 8);
      $display("Ran %0d list ops (%0d results checked) over %0d capacity writes, peak fill %0d.",
               ops_accepted, rsp_checked, cap_writes, peak_fill);
      $display("Status mix: %0d ok, %0d null handle, %0d out of range, %0d full.",
               status_seen[ST_OK], status_seen[ST_NULL], status_seen[ST_RANGE],
               status_seen[ST_FULL]);
      if (error_count == 0 && rsp_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, rsp_due.size());
      $display("Verification failed");
      $finish;
   end

endmodule
